// File: hw/rtl/vm_data_memory_rmw_alu_macros.svh
// Assertion macros for the VM data memory RMW block.
// Depends on nothing; included by RTL files that check their own logic.
`ifndef VM_DATA_MEMORY_RMW_ALU_MACROS_SVH
`define VM_DATA_MEMORY_RMW_ALU_MACROS_SVH

// Implication check under the active-low reset.
`define VMD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check under the active-low reset.
`define VMD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/vmd_pkg.sv
// Package for the VM data memory RMW block: beat types, mode and status codes.
// Depends on nothing.
package vmd_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STORE_WORDS = (MEM_BYTES + 7) / 8;
    localparam int WIDX_W      = $clog2(STORE_WORDS);
    localparam int WCNT_W      = $clog2(STORE_WORDS + 1);

    localparam logic [3:0] MODE_READ  = 4'd0;
    localparam logic [3:0] MODE_WRITE = 4'd1;
    localparam logic [3:0] MODE_ADD   = 4'd2;
    localparam logic [3:0] MODE_SUB   = 4'd3;
    localparam logic [3:0] MODE_MUL   = 4'd4;
    localparam logic [3:0] MODE_DIV   = 4'd5;
    localparam logic [3:0] MODE_REM   = 4'd6;
    localparam logic [3:0] MODE_OR    = 4'd7;
    localparam logic [3:0] MODE_XOR   = 4'd8;
    localparam logic [3:0] MODE_AND   = 4'd9;
    localparam logic [3:0] MODE_SHR   = 4'd10;
    localparam logic [3:0] MODE_SHL   = 4'd11;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIVZ  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]  mode;
        logic        word_access;
        logic [19:0] location;
        logic [63:0] operand;
    } req_t;

    typedef struct packed {
        logic [63:0] data;
        logic [1:0]  status;
    } rsp_t;

endpackage

// File: hw/rtl/vm_data_memory_rmw_alu.sv
// Top level of the VM data memory: handshake, clear sweep, RMW sequencer, ALU.
// Depends on vmd_pkg, vmd_ram, vmd_divider, vmd_multiplier and the macro header.
//
//   channel | ports                 | handshake
//   --------+-----------------------+----------------------------------
//   request | start, busy, req      | beat taken when start && !busy
//   result  | done, rsp             | beat shown for one cycle on done
//
// A read or simple op goes through S_READ (RAM read), S_CALC (compute) and
// S_WB (write back with result). mul waits in S_WAIT for the partial-product unit;
// div and rem wait there for the bit-serial divider. A range fault finishes
// straight from idle; a zero divisor is caught after the read, in S_CALC.
// After reset, busy holds high while the clear sweep zeroes all STORE_WORDS
// (512) words of the RAM. The receiver cannot stall results.
`include "vm_data_memory_rmw_alu_macros.svh"
module vm_data_memory_rmw_alu
    import vmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [WCNT_W-1:0] clr_reg, clr_next;
    req_t              req_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [2:0]        bsel_reg;
    logic [63:0]       old_reg, res_reg, res_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ram_we;
    logic [WIDX_W-1:0] ram_addr;
    logic [63:0]       ram_wdata, ram_rdata;

    logic              in_range;
    logic              accept;
    logic [63:0]       a_val, b_val, simple;
    logic [6:0]        width;
    logic              is_mul, is_div;
    logic              mul_go, mul_done, div_go, div_done;
    logic [63:0]       mul_p, div_q, div_r;
    logic [63:0]       merged, wide_res;

    assign accept = start && !busy;

    // Range check: byte needs addr < MEM_BYTES, word needs index*8+8 <= MEM_BYTES.
    always_comb
    begin
        if (req.word_access)
        begin
            in_range = ({3'd0, req.location} < 23'(MEM_BYTES / 8));
        end
        else
        begin
            in_range = ({1'b0, req.location} < 21'(MEM_BYTES));
        end
    end

    // Operands: byte access uses one byte lane of the old word and operand[7:0].
    assign a_val = req_reg.word_access ? ram_rdata
                 : {56'd0, ram_rdata[{bsel_reg, 3'd0} +: 8]};
    assign b_val = req_reg.word_access ? req_reg.operand : {56'd0, req_reg.operand[7:0]};
    assign width = req_reg.word_access ? 7'd64 : 7'd8;
    assign is_mul = (req_reg.mode == MODE_MUL);
    assign is_div = (req_reg.mode == MODE_DIV) || (req_reg.mode == MODE_REM);

    always_comb
    begin
        case (req_reg.mode)
            MODE_WRITE: simple = b_val;
            MODE_ADD:   simple = a_val + b_val;
            MODE_SUB:   simple = a_val - b_val;
            MODE_OR:    simple = a_val | b_val;
            MODE_XOR:   simple = a_val ^ b_val;
            MODE_AND:   simple = a_val & b_val;
            MODE_SHR:   simple = (b_val >= 64'(width)) ? 64'd0 : (a_val >> b_val[5:0]);
            MODE_SHL:   simple = (b_val >= 64'(width)) ? 64'd0 : (a_val << b_val[5:0]);
            default:    simple = a_val;
        endcase
    end

    assign mul_go = (state_reg == S_CALC) && is_mul;
    assign div_go = (state_reg == S_CALC) && is_div && (b_val != 64'd0);

    vmd_multiplier u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .a       (a_val),
        .b       (b_val),
        .done    (mul_done),
        .product (mul_p)
    );

    vmd_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (a_val),
        .divisor   (b_val),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Mask to access width and merge the byte lane into the old word.
    assign wide_res = req_reg.word_access ? res_reg : {56'd0, res_reg[7:0]};
    always_comb
    begin
        merged = old_reg;
        merged[{bsel_reg, 3'd0} +: 8] = res_reg[7:0];
        if (req_reg.word_access)
        begin
            merged = res_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_addr   = widx_reg;
        ram_wdata  = merged;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[WIDX_W-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == WCNT_W'(STORE_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_addr = req.word_access ? req.location[WIDX_W-1:0]
                                           : req.location[WIDX_W+2:3];
                if (accept)
                begin
                    if (!in_range)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{data: 64'd0, status: ST_RANGE};
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                res_next = simple;
                if (is_div && (b_val == 64'd0))
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{data: 64'd0, status: ST_DIVZ};
                    state_next = S_IDLE;
                end
                else if (is_mul || is_div)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_WAIT:
            begin
                if (is_mul && mul_done)
                begin
                    res_next   = mul_p;
                    state_next = S_WB;
                end
                else if (div_done)
                begin
                    res_next   = (req_reg.mode == MODE_DIV) ? div_q : div_r;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                ram_we     = 1'b1;
                done_next  = 1'b1;
                rsp_next   = '{data: wide_res, status: ST_OK};
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    vmd_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Payload: capture the beat on accept, hold old word after the read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req;
            widx_reg <= ram_addr;
            bsel_reg <= req.location[2:0];
        end
        if (state_reg == S_CALC)
        begin
            old_reg <= ram_rdata;
        end
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `VMD_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept && in_range, busy)
    `VMD_ASSERT_NEXT(a_wb_done, clk, rst_n, state_reg == S_WB, done && rsp.status == ST_OK)
    `VMD_ASSERT_IMPL(a_fault_zero, clk, rst_n, done && rsp.status != ST_OK, rsp.data == 64'd0)
    `VMD_ASSERT_IMPL(a_clear_no_done, clk, rst_n, state_reg == S_CLEAR, !done)

endmodule

// File: hw/rtl/vmd_ram.sv
// Single-port synchronous word RAM with registered read.
// Depends on vmd_pkg for the depth.
module vmd_ram
    import vmd_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [WIDX_W-1:0] addr,
    input  logic [63:0]       wdata,
    output logic [63:0]       rdata
);

    logic [63:0] mem [STORE_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/vmd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on vmd_pkg.
module vmd_divider
    import vmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [64:0] trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        run_next = run_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        trial    = {r_reg, q_reg[63]} - {1'b0, d_reg};
        done     = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = 7'd64;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 7'd1;
                if (!trial[64])
                begin
                    r_next = trial[63:0];
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[62:0], q_reg[63]};
                    q_next = {q_reg[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// File: hw/rtl/vmd_multiplier.sv
// 64x64 low-half multiplier from three 32x32 partial products over cycles.
// Depends on vmd_pkg.
module vmd_multiplier
    import vmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    logic [2:0]  ph_reg, ph_next;
    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [31:0] ma, mb;
    logic [63:0] pp_reg;

    always_comb
    begin
        ph_next  = ph_reg;
        acc_next = acc_reg;
        ma       = a_reg[31:0];
        mb       = b_reg[31:0];
        done     = 1'b0;
        case (ph_reg)
            3'd1: begin ma = a_reg[31:0];  mb = b_reg[31:0]; end
            3'd2: begin ma = a_reg[63:32]; mb = b_reg[31:0]; end
            3'd3: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            default: begin ma = a_reg[31:0]; mb = b_reg[31:0]; end
        endcase
        case (ph_reg)
            3'd2: acc_next = pp_reg;
            3'd3: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
            3'd4: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
            default: acc_next = acc_reg;
        endcase
        if (go)
        begin
            ph_next = 3'd1;
        end
        else if (ph_reg == 3'd5)
        begin
            ph_next = 3'd0;
            done    = 1'b1;
        end
        else if (ph_reg != 3'd0)
        begin
            ph_next = ph_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        pp_reg  <= 64'(ma) * 64'(mb);
        acc_reg <= acc_next;
    end

    assign product = acc_reg;

endmodule

// File: bench/tb_vm_data_memory_rmw_alu.sv
// Self-checking bench for vm_data_memory_rmw_alu: random and directed RMW beats.
// Depends on vmd_pkg and the block's RTL; keeps its own shadow copy of memory.
module tb_vm_data_memory_rmw_alu;
    import vmd_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    vm_data_memory_rmw_alu DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // Shadow memory, one 64-bit word per entry, cleared like the block's RAM.
    logic [63:0] shadow_mem [STORE_WORDS];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];

    int errors;
    int beats_sent;
    int rsps_seen;
    int faults_seen;
    bit calm;                // no idling while set
    bit beat_taken;          // a beat was accepted at the last rising edge
    int mode_hits [16];

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to a value of the given width; flag divide by zero.
    function automatic logic [63:0] alu_apply(input logic [3:0] mode,
                                              input logic [63:0] a,
                                              input logic [63:0] b,
                                              input int width,
                                              output bit divz);
        divz = 1'b0;
        case (mode)
            MODE_WRITE: return b;
            MODE_ADD:   return a + b;
            MODE_SUB:   return a - b;
            MODE_MUL:   return a * b;
            MODE_DIV:
            begin
                if (b == 64'd0)
                begin
                    divz = 1'b1;
                    return 64'd0;
                end
                return a / b;
            end
            MODE_REM:
            begin
                if (b == 64'd0)
                begin
                    divz = 1'b1;
                    return 64'd0;
                end
                return a % b;
            end
            MODE_OR:    return a | b;
            MODE_XOR:   return a ^ b;
            MODE_AND:   return a & b;
            MODE_SHR:   return (b >= width) ? 64'd0 : (a >> b);
            MODE_SHL:   return (b >= width) ? 64'd0 : (a << b);
            default:    return a;
        endcase
    endfunction

    // Work out the response to one accepted beat and update the shadow memory.
    function automatic rsp_t memory_result(input req_t r);
        rsp_t o;
        bit divz;
        logic [63:0] old_val;
        logic [63:0] res;
        int sh;
        int widx;
        o.data = 64'd0;
        o.status = ST_OK;
        if (r.word_access)
        begin
            if (r.location >= STORE_WORDS || int'(r.location) * 8 + 8 > MEM_BYTES)
            begin
                o.status = ST_RANGE;
                return o;
            end
            widx = int'(r.location);
            res = alu_apply(r.mode, shadow_mem[widx], r.operand, 64, divz);
            if (divz)
            begin
                o.status = ST_DIVZ;
                return o;
            end
            shadow_mem[widx] = res;
            o.data = res;
            return o;
        end
        if (r.location >= MEM_BYTES)
        begin
            o.status = ST_RANGE;
            return o;
        end
        widx = int'(r.location >> 3);
        sh = int'(r.location[2:0]) * 8;
        old_val = (shadow_mem[widx] >> sh) & 64'hFF;
        res = alu_apply(r.mode, old_val, {56'd0, r.operand[7:0]}, 8, divz) & 64'hFF;
        if (divz)
        begin
            o.status = ST_DIVZ;
            return o;
        end
        shadow_mem[widx] = (shadow_mem[widx] & ~(64'hFF << sh)) | (res << sh);
        o.data = res;
        return o;
    endfunction

    function automatic req_t make_beat(input logic [3:0] mode, input bit word,
                                       input logic [19:0] loc,
                                       input logic [63:0] opnd);
        req_t r;
        r.mode = mode;
        r.word_access = word;
        r.location = loc;
        r.operand = opnd;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pick an operand: mostly small or boundary values so shifts and
    // divides hit interesting cases, otherwise fully random.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'($urandom_range(0, 70));
            2: return '1;
            3: return 64'h8000_0000_0000_0000;
            default: return rand64();
        endcase
    endfunction

    // Keep locations mostly inside a small hot region so RMW chains
    // pile up on the same words; sometimes go to the edges or out of range.
    function automatic req_t random_beat();
        logic [3:0] mode;
        bit word;
        logic [19:0] loc;
        mode = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 8)
            mode = 4'($urandom_range(0, 11));
        word = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: loc = 20'($urandom());
            1: loc = word ? 20'(STORE_WORDS - 1 + $urandom_range(0, 1))
                          : 20'(MEM_BYTES - 1 + $urandom_range(0, 1));
            2: loc = word ? 20'($urandom_range(0, STORE_WORDS - 1))
                          : 20'($urandom_range(0, MEM_BYTES - 1));
            default: loc = word ? 20'($urandom_range(0, 7)) : 20'($urandom_range(0, 63));
        endcase
        return make_beat(mode, word, loc, pick_operand());
    endfunction

    // Driver: present beats at the falling edge, hold until taken.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
        end
        else if (!start || beat_taken)
        begin
            // nothing shown, or the shown beat was taken at the last rising edge
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 10))
            begin
                start <= 1'b1;
                req <= pending_reqs.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predict on accept, check on done.
    always @(posedge clk)
    begin
        beat_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                rsps_seen++;
                if (rsp.status != ST_OK)
                    faults_seen++;
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: data=%h status=%0d",
                             $time, rsp.data, rsp.status);
                end
                else
                begin
                    rsp_t exp_r;
                    exp_r = expected_rsps.pop_front();
                    if (rsp.data !== exp_r.data)
                    begin
                        errors++;
                        $display("%0t: data mismatch: expected %h actual %h",
                                 $time, exp_r.data, rsp.data);
                    end
                    if (rsp.status !== exp_r.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, exp_r.status, rsp.status);
                    end
                end
            end
            if (start && !busy)
            begin
                beats_sent++;
                mode_hits[req.mode]++;
                expected_rsps.push_back(memory_result(req));
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int modes_covered;
        errors = 0;
        beats_sent = 0;
        rsps_seen = 0;
        faults_seen = 0;
        calm = 1'b0;
        foreach (shadow_mem[i])
            shadow_mem[i] = 64'd0;
        foreach (mode_hits[i])
            mode_hits[i] = 0;
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every mode, both widths, edges of range, div by zero,
        // full-width shifts, unused modes.
        pending_reqs.push_back(make_beat(MODE_READ, 1'b1, 20'd0, 64'd0));
        pending_reqs.push_back(make_beat(MODE_WRITE, 1'b1, 20'd0, '1));
        pending_reqs.push_back(make_beat(MODE_ADD, 1'b1, 20'd0, 64'd2));
        pending_reqs.push_back(make_beat(MODE_SUB, 1'b1, 20'd0, 64'd5));
        pending_reqs.push_back(make_beat(MODE_MUL, 1'b1, 20'd0, '1));
        pending_reqs.push_back(make_beat(MODE_DIV, 1'b1, 20'd0, 64'd3));
        pending_reqs.push_back(make_beat(MODE_DIV, 1'b1, 20'd0, 64'd0));
        pending_reqs.push_back(make_beat(MODE_REM, 1'b1, 20'd0, 64'd7));
        pending_reqs.push_back(make_beat(MODE_REM, 1'b0, 20'd1, 64'h100));
        pending_reqs.push_back(make_beat(MODE_OR, 1'b0, 20'd2, 64'hA5));
        pending_reqs.push_back(make_beat(MODE_XOR, 1'b0, 20'd2, 64'hFF));
        pending_reqs.push_back(make_beat(MODE_AND, 1'b0, 20'd2, 64'h0F));
        pending_reqs.push_back(make_beat(MODE_SHL, 1'b0, 20'd2, 64'd7));
        pending_reqs.push_back(make_beat(MODE_SHR, 1'b0, 20'd2, 64'd8));
        pending_reqs.push_back(make_beat(MODE_SHL, 1'b1, 20'd0, 64'd64));
        pending_reqs.push_back(make_beat(MODE_WRITE, 1'b1, 20'(STORE_WORDS - 1), 64'h0123_4567_89AB_CDEF));
        pending_reqs.push_back(make_beat(MODE_SHR, 1'b1, 20'(STORE_WORDS - 1), 64'd63));
        pending_reqs.push_back(make_beat(MODE_READ, 1'b1, 20'(STORE_WORDS), 64'd0));
        pending_reqs.push_back(make_beat(MODE_DIV, 1'b1, 20'hFFFFF, 64'd0));
        pending_reqs.push_back(make_beat(MODE_WRITE, 1'b0, 20'(MEM_BYTES - 1), 64'hFFFF_FFFF_FFFF_FF7E));
        pending_reqs.push_back(make_beat(MODE_WRITE, 1'b0, 20'(MEM_BYTES), 64'd1));
        pending_reqs.push_back(make_beat(4'd12, 1'b0, 20'(MEM_BYTES - 1), '1));
        pending_reqs.push_back(make_beat(4'd15, 1'b1, 20'(STORE_WORDS - 1), '1));
        pending_reqs.push_back(make_beat(MODE_READ, 1'b0, 20'h80000, 64'd0));

        // Random: a calm stretch in the middle with no idling.
        for (int i = 0; i < 400; i++)
        begin
            pending_reqs.push_back(random_beat());
            if (i % 50 == 0)
                @(negedge clk);
            while (pending_reqs.size() > 20)
                @(negedge clk);
            calm = (i >= 150 && i < 230);
        end
        calm = 1'b0;
        while (pending_reqs.size() > 0 || start)
            @(negedge clk);
        while (expected_rsps.size() > 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        modes_covered = 0;
        foreach (mode_hits[i])
            if (mode_hits[i] > 0)
                modes_covered++;
        $display("Ran %0d beats over %0d of 16 modes; %0d results, %0d of them faults.",
                 beats_sent, modes_covered, rsps_seen, faults_seen);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: allows for ~424 beats plus the clear sweep, many times over.
    initial
    begin
        #5000000;
        $display("Timed out with %0d results outstanding", expected_rsps.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
